FILE: sv/krq_pkg.sv
// Package: shared opcodes and types for the keyed removal queue.
package krq_pkg;
  localparam int ID_W = 32;
  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_DUMP    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] out_id;
    logic            last;
    logic            dropped;
  } rsp_t;
endpackage

FILE: sv/krq_stream_if.sv
// Interface: valid/ready channel carrying one payload type.
interface krq_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/keyed_removal_queue_core.sv
// Top level: ordered identifier queue with delete by key, memory based.
//
// Channels: in_req (sink) carries {op, id}; out_rsp (source) carries
// {out_id, last, dropped}. A request is accepted when valid and ready are
// both high at a rising clk edge.
// Enqueue: writes the tail entry, or gives one drop response (last=1,
// dropped=1) when the store is full.
// Remove: a scan of the stored entries, one memory read per cycle, until
// the key is found, then a compaction that copies each later entry one
// place up, one entry per cycle.
// Dump: streams entries head to tail, each read in S_DUMP and captured in
// S_WAIT while the receiver takes them; the final one has last=1.
// Empty store gives nothing.
// Throughput is set by the single read port of the entry memory.
// One request is worked at a time; ready is low while a remove or dump runs
// or a response waits. A stalled receiver holds the output register and
// the dump read pointer until the response is taken.
// Reset (rst, synchronous) clears the entry count and control state; memory
// contents are left undefined, entries beyond the count are never used.
module keyed_removal_queue_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input logic clk,
  input logic rst,
  krq_stream_if.sink   in_req,
  krq_stream_if.source out_rsp
);
  import krq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MOVE = 5'b00100,
    S_DUMP = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;     // next address to read
  logic [CW-1:0] rptr, rptr_next;   // address whose data is on rdata
  logic          rvalid, rvalid_next;
  logic [ID_W-1:0] key, key_next;
  logic          ovalid, ovalid_next;
  rsp_t          obuf, obuf_next;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [ID_W-1:0] wdata, rdata;
  logic            acc, take;

  krq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_req.ready  = (state == S_IDLE) && !ovalid;
  assign acc           = in_req.valid && in_req.ready;
  assign out_rsp.valid = ovalid;
  assign out_rsp.data  = obuf;
  assign take          = ovalid && out_rsp.ready;
  // idle reads the head so a remove scan starts on entry 0
  assign raddr         = (state == S_IDLE) ? '0 : ptr[AW-1:0];

  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    rptr_next   = ptr;
    rvalid_next = 1'b0;
    key_next    = key;
    ovalid_next = ovalid && !take;
    obuf_next   = obuf;
    we          = 1'b0;
    waddr       = count[AW-1:0];
    wdata       = in_req.data.id;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_req.data.op)
            OP_ENQUEUE: begin
              if (count == CW'(QUEUE_DEPTH)) begin
                ovalid_next = 1'b1;
                obuf_next   = '{out_id: in_req.data.id, last: 1'b1, dropped: 1'b1};
              end else begin
                we         = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_REMOVE: begin
              key_next = in_req.data.id;
              ptr_next = '0;
              if (count != '0) begin
                state_next = S_SCAN;
                ptr_next   = CW'(1);
                rptr_next  = '0;
                rvalid_next = 1'b1;
              end
            end
            OP_DUMP: begin
              if (count != '0) begin
                state_next = S_DUMP;
                ptr_next   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // rdata holds entry rptr
        if (rvalid && rdata == key) begin
          // entries rptr+1.. move up; ptr already = rptr+1
          state_next  = S_MOVE;
          rptr_next   = ptr;
          rvalid_next = (ptr < count);
          ptr_next    = ptr + 1'b1;
          if (ptr >= count) begin
            count_next = count - 1'b1;
            state_next = S_IDLE;
          end
        end else if (rptr + 1'b1 >= count) begin
          state_next = S_IDLE;
        end else begin
          rptr_next   = ptr;
          rvalid_next = 1'b1;
          ptr_next    = ptr + 1'b1;
        end
      end
      S_MOVE: begin
        // rdata holds entry rptr, goes to rptr-1
        we    = 1'b1;
        waddr = AW'(rptr - 1'b1);
        wdata = rdata;
        if (rptr + 1'b1 >= count) begin
          count_next = count - 1'b1;
          state_next = S_IDLE;
        end else begin
          rptr_next   = ptr;
          rvalid_next = 1'b1;
          ptr_next    = ptr + 1'b1;
        end
      end
      S_DUMP: begin
        // issue read of ptr, then capture in S_WAIT
        rptr_next  = ptr;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!ovalid || take) begin
          ovalid_next = 1'b1;
          obuf_next   = '{out_id: rdata, last: (rptr + 1'b1 == count), dropped: 1'b0};
          if (rptr + 1'b1 == count) begin
            state_next = S_IDLE;
          end else begin
            ptr_next   = rptr + 1'b1;
            state_next = S_DUMP;
          end
        end else begin
          ptr_next  = rptr;
          rptr_next = rptr;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ptr    <= '0;
      rptr   <= '0;
      rvalid <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ptr    <= ptr_next;
      rptr   <= rptr_next;
      rvalid <= rvalid_next;
      ovalid <= ovalid_next;
    end
    key  <= key_next;
    obuf <= obuf_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("count beyond depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_req.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (ovalid && obuf.dropped) |-> obuf.last) else $error("drop without last");
  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (acc && in_req.data.op == OP_ENQUEUE && count != CW'(QUEUE_DEPTH))
      |=> count == $past(count) + 1'b1) else $error("enqueue count");
endmodule

FILE: sv/krq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module krq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
